// ===== rtl/core/gsa_pkg.sv =====
package gsa_pkg;

    // Default pool size
    localparam int GSA_SLOTS = 64;

    // Word layout widths
    localparam int CMD_W    = 3;
    localparam int HIDX_W   = 16;
    localparam int GEN_W    = 32;
    localparam int CODE_W   = 3;
    localparam int SIDX_W   = 6;
    localparam int CNT_W    = 7;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // Slot status codes
    localparam logic [CODE_W-1:0] ST_READY     = 3'd0;
    localparam logic [CODE_W-1:0] ST_COMPLETED = 3'd4;

    // Datapath operation issued by the controller each cycle
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_INIT,
        DP_STACK_RD,
        DP_ALLOC_GEN,
        DP_ALLOC_RES,
        DP_HANDLE_RD,
        DP_HANDLE_DONE,
        DP_WALK_START,
        DP_WALK,
        DP_OUT
    } t_dp_op;

    // Datapath status seen by the controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             depth_zero;
        logic             walk_last;
        logic             out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/generational_slot_allocator_core.sv =====
// Generational slot allocator: a pool of SLOTS slots handed out as
// (index, generation) handles from a LIFO free stack.
// Input channel s_*: one command word per item. s_tuser carries the command
// (allocate, free, check, count, clear); s_tdata carries the handle and the
// status code to count. Output channel m_*: one result word per command.
// Steps per command: allocate pops the stack top, then reads that slot's
// generation, unless the stack is empty; free and check read the handle's
// status and generation; count and clear walk every slot; an unknown
// command goes straight to the result. One command is in flight at a time;
// the next word is taken in the cycle after the result is loaded.
// The steps come from the registered read of the slot memories (stack,
// then generation for allocate) and from the one-entry-per-cycle walk over
// the status and generation memories for count and clear.
// After reset the block runs a clearing pass over every slot that rebuilds
// the free stack and zeroes every generation; s_tready stays low meanwhile.
// The result sits in an output register: a stalled receiver holds it, the
// next command is still accepted and worked, and only its result waits
// until the register frees.
module generational_slot_allocator_core #(
    parameter int SLOTS = gsa_pkg::GSA_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: handle_index[15:0], handle_generation[47:16],
    //          status_code[50:48], zero pad[55:51]
    input  logic [gsa_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: cmd[2:0]
    input  logic [gsa_pkg::CMD_W-1:0]    s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: ok[0], slot_index[6:1], generation[38:7], count[45:39],
    //          zero pad[47:46]
    output logic [gsa_pkg::M_DATA_W-1:0] m_tdata
);
    import gsa_pkg::*;

    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    gsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_stat   (dp_stat),
        .o_op     (dp_op)
    );

    gsa_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (dp_op),
        .o_stat   (dp_stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/core/gsa_ctrl.sv =====
module gsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gsa_pkg::t_dp_stat i_stat,
    output gsa_pkg::t_dp_op   o_op
);
    import gsa_pkg::*;

    typedef enum logic [7:0] {
        S_INIT    = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_DECODE  = 8'b0000_0100,
        S_ALLOC_A = 8'b0000_1000,
        S_ALLOC_B = 8'b0001_0000,
        S_HANDLE  = 8'b0010_0000,
        S_WALK    = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign s_tready = (r_state == S_IDLE);

    // Sequence the datapath per command
    always_comb begin
        n_state = r_state;
        o_op    = DP_NONE;
        unique case (r_state)
            S_INIT: begin
                o_op = DP_INIT;
                if (i_stat.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    o_op    = DP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd) inside
                    CMD_ALLOC: begin
                        if (i_stat.depth_zero) begin
                            n_state = S_RESP;
                        end else begin
                            o_op    = DP_STACK_RD;
                            n_state = S_ALLOC_A;
                        end
                    end
                    CMD_FREE, CMD_CHECK: begin
                        o_op    = DP_HANDLE_RD;
                        n_state = S_HANDLE;
                    end
                    CMD_COUNT, CMD_CLEAR: begin
                        o_op    = DP_WALK_START;
                        n_state = S_WALK;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_ALLOC_A: begin
                o_op    = DP_ALLOC_GEN;
                n_state = S_ALLOC_B;
            end
            S_ALLOC_B: begin
                o_op    = DP_ALLOC_RES;
                n_state = S_RESP;
            end
            S_HANDLE: begin
                o_op    = DP_HANDLE_DONE;
                n_state = S_RESP;
            end
            S_WALK: begin
                o_op = DP_WALK;
                if (i_stat.walk_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_op    = DP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

// ===== rtl/core/gsa_dpath.sv =====
module gsa_dpath #(
    parameter int SLOTS = gsa_pkg::GSA_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gsa_pkg::t_dp_op               i_op,
    output gsa_pkg::t_dp_stat             o_stat,
    input  logic [gsa_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [gsa_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gsa_pkg::M_DATA_W-1:0]  m_tdata
);
    import gsa_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0]     LAST    = IW'(SLOTS - 1);
    localparam logic [CW-1:0]     FULL    = CW'(SLOTS);
    localparam logic [HIDX_W:0]   SLOTS_X = (HIDX_W + 1)'(SLOTS);

    // Slot memories
    logic [CODE_W-1:0] r_stat_mem  [SLOTS];
    logic [GEN_W-1:0]  r_gen_mem   [SLOTS];
    logic [IW-1:0]     r_stack_mem [SLOTS];
    logic [CODE_W-1:0] r_stat_q;
    logic [GEN_W-1:0]  r_gen_q;
    logic [IW-1:0]     r_stack_q;

    logic              stat_we, stat_re, gen_we, gen_re, stack_we, stack_re;
    logic [IW-1:0]     stat_waddr, stat_raddr, gen_waddr, gen_raddr;
    logic [IW-1:0]     stack_waddr, stack_raddr;
    logic [CODE_W-1:0] stat_wdata;
    logic [GEN_W-1:0]  gen_wdata;
    logic [IW-1:0]     stack_wdata;

    // Item and result registers
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [HIDX_W-1:0] r_idx, n_idx;
    logic [GEN_W-1:0]  r_hgen, n_hgen;
    logic [CODE_W-1:0] r_code, n_code;
    logic              r_ok, n_ok;
    logic [IW-1:0]     r_slot, n_slot;
    logic [GEN_W-1:0]  r_sgen, n_sgen;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_depth, n_depth;
    logic [IW-1:0]     r_prev, n_prev;
    logic              r_m_valid;
    logic [M_DATA_W-1:0] r_m_data, n_m_data;

    logic              walk_last, in_range, live, depth_full;
    logic [IW-1:0]     idx_addr, prev_inc;
    logic [CW-1:0]     depth_dec;
    logic [IW+SIDX_W-1:0] slot_ext;
    logic [CW+CNT_W-1:0]  cnt_ext;

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (stat_we) begin
            r_stat_mem[stat_waddr] <= stat_wdata;
        end
        if (stat_re) begin
            r_stat_q <= r_stat_mem[stat_raddr];
        end
        if (gen_we) begin
            r_gen_mem[gen_waddr] <= gen_wdata;
        end
        if (gen_re) begin
            r_gen_q <= r_gen_mem[gen_raddr];
        end
        if (stack_we) begin
            r_stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re) begin
            r_stack_q <= r_stack_mem[stack_raddr];
        end
    end

    assign walk_last  = (r_prev == LAST);
    assign prev_inc   = r_prev + 1'b1;
    assign depth_dec  = r_depth - 1'b1;
    assign depth_full = (r_depth == FULL);
    assign in_range   = ({1'b0, r_idx} < SLOTS_X);
    assign idx_addr   = in_range ? r_idx[IW-1:0] : '0;
    assign live       = in_range && (r_stat_q != ST_COMPLETED) && (r_gen_q == r_hgen);
    assign slot_ext   = {{SIDX_W{1'b0}}, r_slot};
    assign cnt_ext    = {{CNT_W{1'b0}}, r_cnt};

    // Decode the operation into memory accesses and register updates
    always_comb begin
        stat_we     = 1'b0;
        stat_re     = 1'b0;
        gen_we      = 1'b0;
        gen_re      = 1'b0;
        stack_we    = 1'b0;
        stack_re    = 1'b0;
        stat_waddr  = r_prev;
        stat_raddr  = '0;
        gen_waddr   = r_prev;
        gen_raddr   = '0;
        stack_waddr = r_prev;
        stack_raddr = depth_dec[IW-1:0];
        stat_wdata  = ST_COMPLETED;
        gen_wdata   = r_gen_q + 1'b1;
        stack_wdata = LAST - r_prev;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_hgen      = r_hgen;
        n_code      = r_code;
        n_ok        = r_ok;
        n_slot      = r_slot;
        n_sgen      = r_sgen;
        n_cnt       = r_cnt;
        n_depth     = r_depth;
        n_prev      = r_prev;
        n_m_data    = r_m_data;
        unique case (i_op)
            DP_NONE: begin
            end
            DP_LOAD: begin
                n_cmd  = s_tuser;
                n_idx  = s_tdata[HIDX_W-1:0];
                n_hgen = s_tdata[HIDX_W+GEN_W-1:HIDX_W];
                n_code = s_tdata[HIDX_W+GEN_W+CODE_W-1:HIDX_W+GEN_W];
                n_ok   = 1'b0;
                n_slot = '0;
                n_sgen = '0;
                n_cnt  = '0;
            end
            DP_INIT: begin
                // rebuild one entry per cycle after reset
                stat_we   = 1'b1;
                gen_we    = 1'b1;
                gen_wdata = '0;
                stack_we  = 1'b1;
                n_prev    = prev_inc;
                if (walk_last) begin
                    n_prev  = '0;
                    n_depth = FULL;
                end
            end
            DP_STACK_RD: begin
                // pop the top index
                stack_re = 1'b1;
                n_depth  = depth_dec;
            end
            DP_ALLOC_GEN: begin
                gen_re     = 1'b1;
                gen_raddr  = r_stack_q;
                stat_we    = 1'b1;
                stat_waddr = r_stack_q;
                stat_wdata = ST_READY;
                n_slot     = r_stack_q;
            end
            DP_ALLOC_RES: begin
                n_ok   = 1'b1;
                n_sgen = r_gen_q;
            end
            DP_HANDLE_RD: begin
                stat_re    = 1'b1;
                stat_raddr = idx_addr;
                gen_re     = 1'b1;
                gen_raddr  = idx_addr;
            end
            DP_HANDLE_DONE: begin
                if (r_cmd == CMD_CHECK) begin
                    n_ok = live;
                end else if (live && !depth_full) begin
                    // retire the slot and push its index
                    gen_we      = 1'b1;
                    gen_waddr   = idx_addr;
                    stat_we     = 1'b1;
                    stat_waddr  = idx_addr;
                    stack_we    = 1'b1;
                    stack_waddr = r_depth[IW-1:0];
                    stack_wdata = idx_addr;
                    n_depth     = r_depth + 1'b1;
                    n_ok        = 1'b1;
                end
            end
            DP_WALK_START: begin
                n_ok       = 1'b1;
                n_prev     = '0;
                stat_re    = 1'b1;
                gen_re     = 1'b1;
            end
            DP_WALK: begin
                // handle entry r_prev, fetch the next one
                if (!walk_last) begin
                    stat_re    = 1'b1;
                    stat_raddr = prev_inc;
                    gen_re     = 1'b1;
                    gen_raddr  = prev_inc;
                    n_prev     = prev_inc;
                end else begin
                    n_prev = '0;
                end
                if (r_cmd == CMD_COUNT) begin
                    if (r_stat_q == r_code) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    stat_we  = 1'b1;
                    gen_we   = 1'b1;
                    stack_we = 1'b1;
                    if (walk_last) begin
                        n_depth = FULL;
                    end
                end
            end
            DP_OUT: begin
                n_m_data = {2'b00, cnt_ext[CNT_W-1:0], r_sgen,
                            slot_ext[SIDX_W-1:0], r_ok};
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= FULL;
            r_prev    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_prev  <= n_prev;
            if (i_op == DP_OUT) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_hgen   <= n_hgen;
        r_code   <= n_code;
        r_ok     <= n_ok;
        r_slot   <= n_slot;
        r_sgen   <= n_sgen;
        r_cnt    <= n_cnt;
        r_m_data <= n_m_data;
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.depth_zero = (r_depth == '0);
    assign o_stat.walk_last  = walk_last;
    assign o_stat.out_free   = !r_m_valid || m_tready;
    assign m_tvalid          = r_m_valid;
    assign m_tdata           = r_m_data;

endmodule

// ===== tb/sv/tb_generational_slot_allocator_core.sv =====
module tb_generational_slot_allocator_core;

    import gsa_pkg::*;

    // Command codes the block does not know
    localparam logic [CMD_W-1:0] CMD_RSV5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSV6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSV7 = 3'd7;

    localparam int CODE_SPAN    = 1 << CODE_W;
    localparam int RANDOM_ITEMS = 1900;
    localparam int TAIL_CYCLES  = GSA_SLOTS + 16;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int PAD_W        = S_DATA_W - HIDX_W - GEN_W - CODE_W;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [HIDX_W-1:0] hidx;
        logic [GEN_W-1:0]  hgen;
        logic [CODE_W-1:0] code;
    } t_pool_cmd;

    typedef struct packed {
        logic              ok;
        logic [SIDX_W-1:0] sidx;
        logic [GEN_W-1:0]  gen;
        logic [CNT_W-1:0]  cnt;
    } t_pool_reply;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // s_tdata: handle_index[15:0], handle_generation[47:16], status_code[50:48], pad
    logic [S_DATA_W-1:0] s_tdata  = '0;
    // s_tuser: cmd[2:0]
    logic [CMD_W-1:0]    s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // m_tdata: ok[0], slot_index[6:1], generation[38:7], count[45:39], pad
    logic [M_DATA_W-1:0] m_tdata;

    // Words waiting to be sent and replies waiting to arrive
    t_pool_cmd   cmd_backlog[$];
    t_pool_reply replies_due[$];
    t_pool_cmd   cur_cmd;
    int unsigned words_queued = 0;
    int unsigned words_taken  = 0;
    int unsigned err_count    = 0;
    int unsigned cycle_count  = 0;

    // Predicted pool state
    logic [CODE_W-1:0] pool_status [GSA_SLOTS];
    logic [GEN_W-1:0]  pool_gen    [GSA_SLOTS];
    logic [SIDX_W-1:0] free_stack  [GSA_SLOTS];
    int                free_depth;
    int                live_slots[$];

    generational_slot_allocator_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Refill the stack with 0 on top and mark every slot completed
    function automatic void rebuild_free_stack();
        for (int i = 0; i < GSA_SLOTS; i++) begin
            free_stack[i]  = SIDX_W'(GSA_SLOTS - 1 - i);
            pool_status[i] = ST_COMPLETED;
        end
        free_depth = GSA_SLOTS;
    endfunction

    function automatic bit handle_is_live(t_pool_cmd c);
        if (int'(c.hidx) >= GSA_SLOTS) return 1'b0;
        if (pool_status[int'(c.hidx)] == ST_COMPLETED) return 1'b0;
        return pool_gen[int'(c.hidx)] == c.hgen;
    endfunction

    // Apply one accepted command to the pool and queue the reply it must give
    function automatic void predict_pool_reply(t_pool_cmd c);
        t_pool_reply r;
        int          s;
        int          n;
        r = '0;
        n = 0;
        case (c.op)
            CMD_ALLOC: begin
                if (free_depth > 0) begin
                    free_depth--;
                    s = int'(free_stack[free_depth]);
                    pool_status[s] = ST_READY;
                    r.ok   = 1'b1;
                    r.sidx = SIDX_W'(s);
                    r.gen  = pool_gen[s];
                end
            end
            CMD_FREE: begin
                if (handle_is_live(c) && free_depth < GSA_SLOTS) begin
                    s = int'(c.hidx);
                    pool_gen[s]    = pool_gen[s] + 1'b1;
                    pool_status[s] = ST_COMPLETED;
                    free_stack[free_depth] = SIDX_W'(s);
                    free_depth++;
                    r.ok = 1'b1;
                end
            end
            CMD_CHECK: r.ok = handle_is_live(c);
            CMD_COUNT: begin
                for (int i = 0; i < GSA_SLOTS; i++)
                    if (pool_status[i] == c.code) n++;
                r.ok  = 1'b1;
                r.cnt = CNT_W'(n);
            end
            CMD_CLEAR: begin
                rebuild_free_stack();
                for (int i = 0; i < GSA_SLOTS; i++) pool_gen[i] = pool_gen[i] + 1'b1;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        replies_due.push_back(r);
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] op, logic [HIDX_W-1:0] hidx,
                                      logic [GEN_W-1:0] hgen, logic [CODE_W-1:0] code);
        t_pool_cmd c;
        c.op   = op;
        c.hidx = hidx;
        c.hgen = hgen;
        c.code = code;
        cmd_backlog.push_back(c);
        words_queued++;
    endfunction

    function automatic void gather_live_slots();
        live_slots.delete();
        for (int i = 0; i < GSA_SLOTS; i++)
            if (pool_status[i] != ST_COMPLETED) live_slots.push_back(i);
    endfunction

    // Mostly short stalls, a few long ones
    function automatic int unsigned draw_stall_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    // Hold until every queued word is taken, optionally until every reply is in
    task automatic wait_quiet(bit and_replies);
        while (words_taken != words_queued || (and_replies && replies_due.size() != 0))
            @(negedge i_clk);
    endtask

    // Send words from the backlog, with idle gaps between them
    int unsigned send_wait = 0;
    int unsigned calm_left = 0;
    bit          calm_mode = 1'b0;

    always @(posedge i_clk) begin : drive_commands
        if (!i_rst_n) begin
            rebuild_free_stack();
            for (int i = 0; i < GSA_SLOTS; i++) pool_gen[i] = '0;
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            // retire the word taken at this edge and pick the gap after it
            if (s_tvalid && s_tready) begin
                predict_pool_reply(cur_cmd);
                words_taken++;
                if (calm_left == 0) begin
                    calm_left = $urandom_range(5, 40);
                    calm_mode = ($urandom_range(0, 2) == 0);
                end
                calm_left--;
                send_wait = calm_mode ? 0 : draw_stall_len();
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    cur_cmd = cmd_backlog.pop_front();
                    s_tuser  <= cur_cmd.op;
                    s_tdata  <= {{PAD_W{1'b0}}, cur_cmd.code, cur_cmd.hgen, cur_cmd.hidx};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Pace the receiver; once, hold it off long enough to back up the input
    int unsigned rx_cycle  = 0;
    int unsigned rx_left   = 0;
    bit          rx_ready  = 1'b0;
    bit          long_hold_done = 1'b0;

    always @(posedge i_clk) begin : pace_receiver
        int unsigned stall;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_left = 0;
        end else begin
            rx_cycle++;
            if (!long_hold_done && rx_cycle > 3000 && s_tvalid && m_tvalid) begin
                long_hold_done = 1'b1;
                rx_ready = 1'b0;
                rx_left  = 400;
            end else if (rx_left == 0) begin
                stall = draw_stall_len();
                if (stall == 0 || $urandom_range(0, 99) < 50) begin
                    rx_ready = 1'b1;
                    rx_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                            : $urandom_range(1, 24);
                end else begin
                    rx_ready = 1'b0;
                    rx_left  = stall;
                end
            end
            rx_left--;
            m_tready <= rx_ready;
        end
    end

    // Compare each reply word with the oldest prediction
    always @(posedge i_clk) begin : check_replies
        t_pool_reply want;
        t_pool_reply got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.ok   = m_tdata[0];
            got.sidx = m_tdata[6:1];
            got.gen  = m_tdata[38:7];
            got.cnt  = m_tdata[45:39];
            if (replies_due.size() == 0) begin
                $error("reply word with no command outstanding: %0h", m_tdata);
                err_count++;
            end else begin
                want = replies_due.pop_front();
                if (got.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, got.ok);
                    err_count++;
                end
                if (got.sidx !== want.sidx) begin
                    $error("slot_index: expected %0d, got %0d", want.sidx, got.sidx);
                    err_count++;
                end
                if (got.gen !== want.gen) begin
                    $error("generation: expected %0h, got %0h", want.gen, got.gen);
                    err_count++;
                end
                if (got.cnt !== want.cnt) begin
                    $error("count: expected %0d, got %0d", want.cnt, got.cnt);
                    err_count++;
                end
            end
        end
    end

    // Give up on a hung block
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_generational_slot_allocator_core: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned kind;
        int unsigned pick;
        int unsigned n;
        int unsigned j;
        int unsigned idx;
        int unsigned phase;
        int unsigned random_items;
        int unsigned base_count;
        logic [GEN_W-1:0] g;

        phase = 0;
        random_items = 0;

        // Directed: fresh pool, live and stale handles, bad frees, every code
        queue_cmd(CMD_COUNT, '0, '0, ST_COMPLETED);
        queue_cmd(CMD_CHECK, '0, '0, '0);
        queue_cmd(CMD_ALLOC, '1, '1, '1);
        queue_cmd(CMD_ALLOC, '0, '0, '0);
        queue_cmd(CMD_CHECK, '0, '0, '0);
        queue_cmd(CMD_CHECK, '0, '1, '0);
        queue_cmd(CMD_CHECK, '1, '0, '0);
        queue_cmd(CMD_CHECK, HIDX_W'(GSA_SLOTS), '0, '0);
        queue_cmd(CMD_FREE, 16'd1, '0, '0);
        queue_cmd(CMD_FREE, 16'd1, '0, '0);
        queue_cmd(CMD_FREE, 16'd1, 32'd1, '0);
        queue_cmd(CMD_FREE, '1, '1, '1);
        for (int code = 0; code < CODE_SPAN; code++)
            queue_cmd(CMD_COUNT, '1, '1, CODE_W'(code));
        queue_cmd(CMD_RSV5, '1, '1, '1);
        queue_cmd(CMD_RSV6, '1, '1, '1);
        queue_cmd(CMD_RSV7, '1, '1, '1);
        queue_cmd(CMD_CLEAR, '0, '0, '0);
        queue_cmd(CMD_CHECK, '0, '0, '0);
        queue_cmd(CMD_ALLOC, '0, '0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random phases, each built from the pool state once the last one is taken
        while (random_items < RANDOM_ITEMS) begin
            wait_quiet(phase % 6 == 5);
            gather_live_slots();
            base_count = words_queued;
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // churn: allocate, free and check mixed, some handles broken
                n = $urandom_range(15, 40);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    if (live_slots.size() > 0)
                        idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
                    else
                        idx = $urandom_range(0, GSA_SLOTS - 1);
                    g = pool_gen[idx];
                    if (pick < 40)
                        queue_cmd(CMD_ALLOC, HIDX_W'($urandom), $urandom, CODE_W'($urandom));
                    else if (pick < 70)
                        queue_cmd(CMD_FREE, HIDX_W'(idx), g, CODE_W'($urandom));
                    else if (pick < 80)
                        queue_cmd(CMD_CHECK, HIDX_W'(idx), g, CODE_W'($urandom));
                    else if (pick < 90)
                        queue_cmd(pick[0] ? CMD_FREE : CMD_CHECK, HIDX_W'(idx),
                                  $urandom_range(0, 1) ? g + 1'b1 : g - 1'b1, '0);
                    else if (pick < 95)
                        queue_cmd(CMD_COUNT, '0, '0, CODE_W'($urandom));
                    else
                        queue_cmd(CMD_CHECK, HIDX_W'($urandom), $urandom, '0);
                end
            end else if (kind < 50) begin
                // fill: run the stack dry and try a few more
                n = free_depth + $urandom_range(1, 3);
                repeat (n)
                    queue_cmd(CMD_ALLOC, HIDX_W'($urandom), $urandom, CODE_W'($urandom));
                queue_cmd(CMD_COUNT, '0, '0, ST_READY);
            end else if (kind < 65) begin
                // drain: free every live handle in random order, then once more
                idx = 0;
                while (live_slots.size() > 0) begin
                    j = $urandom_range(0, live_slots.size() - 1);
                    idx = live_slots[j];
                    live_slots.delete(j);
                    queue_cmd(CMD_FREE, HIDX_W'(idx), pool_gen[idx], CODE_W'($urandom));
                end
                queue_cmd(CMD_FREE, HIDX_W'(idx), pool_gen[idx], '0);
                queue_cmd(CMD_COUNT, '0, '0, ST_COMPLETED);
            end else if (kind < 72) begin
                // clear, then reuse; an old handle must be dead
                idx = (live_slots.size() > 0) ? live_slots[0] : 0;
                g = pool_gen[idx];
                queue_cmd(CMD_CLEAR, HIDX_W'($urandom), $urandom, CODE_W'($urandom));
                repeat ($urandom_range(1, 6)) queue_cmd(CMD_ALLOC, '0, '0, '0);
                queue_cmd(CMD_CHECK, HIDX_W'(idx), g, '0);
            end else if (kind < 85) begin
                // noise: every field random
                n = $urandom_range(10, 20);
                repeat (n)
                    queue_cmd(CMD_W'($urandom), HIDX_W'($urandom), $urandom, CODE_W'($urandom));
            end else begin
                // sweep: check random slots, some with a flipped generation bit, and out of range
                n = $urandom_range(10, 20);
                repeat (n) begin
                    if ($urandom_range(0, 7) == 0) begin
                        queue_cmd(CMD_CHECK, HIDX_W'($urandom_range(GSA_SLOTS, 65535)),
                                  $urandom, '0);
                    end else begin
                        idx = $urandom_range(0, GSA_SLOTS - 1);
                        g = pool_gen[idx];
                        if ($urandom_range(0, 3) == 0) g = g ^ (32'd1 << $urandom_range(0, 31));
                        queue_cmd(CMD_CHECK, HIDX_W'(idx), g, CODE_W'($urandom));
                    end
                end
            end
            random_items += words_queued - base_count;
            phase++;
        end

        // Drain, then let the block settle
        wait_quiet(1'b1);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (replies_due.size() != 0) begin
            $error("%0d replies never arrived", replies_due.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("tb_generational_slot_allocator_core: clean");
        end else begin
            $display("tb_generational_slot_allocator_core: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gsa_pkg.sv
rtl/core/gsa_ctrl.sv
rtl/core/gsa_dpath.sv
rtl/core/generational_slot_allocator_core.sv
tb/sv/tb_generational_slot_allocator_core.sv
